// ===== rtl/bcd_time_date_counter_top_macros.svh =====
// assertion macros for the bcd time and date counter
// used by bcd_time_date_counter_top, no other dependencies
`ifndef BCD_TIME_DATE_COUNTER_TOP_MACROS_SVH
`define BCD_TIME_DATE_COUNTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define BTDC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define BTDC_ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define BTDC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define BTDC_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define BTDC_ASSERT_IMPLIES(lbl, clk, rst_n, a, b)
`define BTDC_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

// ===== rtl/btdc_pkg.sv =====
// types, request codes and digit helpers for the bcd time and date counter
// no dependencies
`default_nettype none

package btdc_pkg;

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_SET_TIME = 2'd1,
		REQ_SET_DATE = 2'd2
	} req_code_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  set_hours;
		logic [5:0]  set_minutes;
		logic [5:0]  set_seconds;
		logic [9:0]  set_millis;
		logic [15:0] set_year;
		logic [3:0]  set_month;
		logic [4:0]  set_day;
	} req_t;

	typedef struct packed {
		logic [9:0]  millis;
		logic [3:0]  second_units;
		logic [2:0]  second_tens;
		logic [3:0]  minute_units;
		logic [2:0]  minute_tens;
		logic [3:0]  hour_units;
		logic [1:0]  hour_tens;
		logic [3:0]  day_units;
		logic [1:0]  day_tens;
		logic [3:0]  month_units;
		logic        month_tens;
		logic [15:0] year_now;
	} rsp_t;

	localparam logic [9:0] TICK_INC_RESET = 10'd100;

	// 20:26:30.000, day 16, month 04, year 2024
	localparam rsp_t RESET_STATE = '{
		millis: 10'd0,
		second_units: 4'd0, second_tens: 3'd3,
		minute_units: 4'd6, minute_tens: 3'd2,
		hour_units: 4'd0, hour_tens: 2'd2,
		day_units: 4'd6, day_tens: 2'd1,
		month_units: 4'd4, month_tens: 1'b0,
		year_now: 16'd2024
	};

	// two digits to binary, values below 64
	function automatic logic [5:0] bcd_to_bin(input logic [2:0] tens, input logic [3:0] units);
		return 6'(tens) * 6'd10 + 6'(units);
	endfunction

	// binary below 60 to {tens, units}
	function automatic logic [6:0] bin_to_bcd(input logic [5:0] v);
		logic [2:0] t;
		logic [5:0] rem;
		if (v >= 6'd50)
			t = 3'd5;
		else if (v >= 6'd40)
			t = 3'd4;
		else if (v >= 6'd30)
			t = 3'd3;
		else if (v >= 6'd20)
			t = 3'd2;
		else if (v >= 6'd10)
			t = 3'd1;
		else
			t = 3'd0;
		rem = v - 6'(t) * 6'd10;
		return {t, rem[3:0]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bcd_time_date_counter_top.sv =====
// bcd time and date counter: request stage, then the state register; one
// request per cycle unless rsp_ready stalls the result; the clock and calendar
// state updates from the registered request and is the result register
// asynchronous active-low reset loads 20:26:30.000, day 16, month 04, 2024
// and a tick increment of 100 ms
// depends on btdc_pkg, btdc_update and bcd_time_date_counter_top_macros.svh
`default_nettype none
`include "bcd_time_date_counter_top_macros.svh"

module bcd_time_date_counter_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           tick_wr_en,
	input  wire logic [9:0]     tick_wr_data,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire btdc_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output btdc_pkg::rsp_t      rsp
);

	logic [9:0]     tick_ms_q;
	logic           valid_s1;
	btdc_pkg::req_t req_s1;
	btdc_pkg::rsp_t state_q;
	btdc_pkg::rsp_t state_nxt;
	logic           rsp_valid_q;
	logic           advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = state_q;

	// tick increment register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ms_q <= btdc_pkg::TICK_INC_RESET;
		end else begin
			if (tick_wr_en)
				tick_ms_q <= tick_wr_data;
		end
	end

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
	end

	btdc_update u_update (
		.cur      (state_q),
		.req      (req_s1),
		.tick_inc (tick_ms_q),
		.nxt      (state_nxt)
	);

	// clock state, doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btdc_pkg::RESET_STATE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`BTDC_ASSERT_ALWAYS(a_hour_legal, clk, arst_n, (state_q.hour_tens != 2'd2) || (state_q.hour_units <= 4'd3))
	`BTDC_ASSERT_ALWAYS(a_day_nonzero, clk, arst_n, (state_q.day_tens != 2'd0) || (state_q.day_units != 4'd0))
	`BTDC_ASSERT_NEXT(a_advance_gives_rsp, clk, arst_n, advance, rsp_valid_q)
	`BTDC_ASSERT_NEXT(a_held_state, clk, arst_n, !advance, $stable(state_q))

endmodule

`default_nettype wire

// ===== rtl/btdc_update.sv =====
// next-state logic: tick carry chain, set time and set date with clamping
// depends on btdc_pkg
`default_nettype none

module btdc_update (
	input  wire btdc_pkg::rsp_t cur,
	input  wire btdc_pkg::req_t req,
	input  wire logic [9:0]     tick_inc,
	output btdc_pkg::rsp_t      nxt
);

	logic [10:0] ms_sum;
	logic [10:0] ms_new;
	logic [1:0]  carry;
	logic [6:0]  s_sum;
	logic [5:0]  s_new;
	logic [5:0]  m_new;
	logic [5:0]  h_new;
	logic [5:0]  d_new;
	logic [5:0]  mo_new;
	logic [15:0] yr_new;
	logic        wrap_s;
	logic        wrap_m;
	logic        wrap_h;
	logic        wrap_d;
	logic        wrap_mo;
	logic [5:0]  m_cur;
	logic [5:0]  h_cur;
	logic [5:0]  d_cur;
	logic [5:0]  mo_cur;
	logic [5:0]  ld_h;
	logic [5:0]  ld_m;
	logic [5:0]  ld_s;
	logic [5:0]  ld_d;
	logic [5:0]  ld_mo;
	logic [9:0]  ld_ms;
	logic [6:0]  bs;
	logic [6:0]  bm;
	logic [6:0]  bh;
	logic [6:0]  bd;
	logic [6:0]  bmo;

	always_comb begin
		// tick path
		ms_sum = {1'b0, cur.millis} + {1'b0, tick_inc};
		if (ms_sum >= 11'd2000) begin
			ms_new = ms_sum - 11'd2000;
			carry  = 2'd2;
		end else if (ms_sum >= 11'd1000) begin
			ms_new = ms_sum - 11'd1000;
			carry  = 2'd1;
		end else begin
			ms_new = ms_sum;
			carry  = 2'd0;
		end

		s_sum  = {1'b0, btdc_pkg::bcd_to_bin(cur.second_tens, cur.second_units)}
			+ 7'(carry);
		wrap_s = s_sum >= 7'd60;
		s_new  = wrap_s ? 6'(s_sum - 7'd60) : s_sum[5:0];

		m_cur  = btdc_pkg::bcd_to_bin(cur.minute_tens, cur.minute_units);
		wrap_m = wrap_s && (m_cur == 6'd59);
		m_new  = wrap_m ? 6'd0 : m_cur + 6'(wrap_s);

		h_cur  = btdc_pkg::bcd_to_bin({1'b0, cur.hour_tens}, cur.hour_units);
		wrap_h = wrap_m && (h_cur == 6'd23);
		h_new  = wrap_h ? 6'd0 : h_cur + 6'(wrap_m);

		d_cur  = btdc_pkg::bcd_to_bin({1'b0, cur.day_tens}, cur.day_units);
		wrap_d = wrap_h && (d_cur >= 6'd30);
		d_new  = wrap_d ? 6'd1 : d_cur + 6'(wrap_h);

		mo_cur  = btdc_pkg::bcd_to_bin({2'b00, cur.month_tens}, cur.month_units);
		wrap_mo = wrap_d && (mo_cur >= 6'd12);
		mo_new  = wrap_mo ? 6'd1 : mo_cur + 6'(wrap_d);

		yr_new = cur.year_now + 16'(wrap_mo);

		// load path, clamped
		ld_h  = (req.set_hours > 5'd23) ? 6'd23 : 6'(req.set_hours);
		ld_m  = (req.set_minutes > 6'd59) ? 6'd59 : req.set_minutes;
		ld_s  = (req.set_seconds > 6'd59) ? 6'd59 : req.set_seconds;
		ld_ms = (req.set_millis > 10'd999) ? 10'd999 : req.set_millis;
		if (req.set_month == 4'd0)
			ld_mo = 6'd1;
		else if (req.set_month > 4'd12)
			ld_mo = 6'd12;
		else
			ld_mo = 6'(req.set_month);
		if (req.set_day == 5'd0)
			ld_d = 6'd1;
		else if (req.set_day > 5'd30)
			ld_d = 6'd30;
		else
			ld_d = 6'(req.set_day);

		nxt = cur;
		case (req.req_type)
			btdc_pkg::REQ_TICK: begin
				bs  = btdc_pkg::bin_to_bcd(s_new);
				bm  = btdc_pkg::bin_to_bcd(m_new);
				bh  = btdc_pkg::bin_to_bcd(h_new);
				bd  = btdc_pkg::bin_to_bcd(d_new);
				bmo = btdc_pkg::bin_to_bcd(mo_new);
				nxt.millis       = ms_new[9:0];
				nxt.second_tens  = bs[6:4];
				nxt.second_units = bs[3:0];
				nxt.minute_tens  = bm[6:4];
				nxt.minute_units = bm[3:0];
				nxt.hour_tens    = bh[5:4];
				nxt.hour_units   = bh[3:0];
				nxt.day_tens     = bd[5:4];
				nxt.day_units    = bd[3:0];
				nxt.month_tens   = bmo[4];
				nxt.month_units  = bmo[3:0];
				nxt.year_now     = yr_new;
			end
			btdc_pkg::REQ_SET_TIME: begin
				bs  = btdc_pkg::bin_to_bcd(ld_s);
				bm  = btdc_pkg::bin_to_bcd(ld_m);
				bh  = btdc_pkg::bin_to_bcd(ld_h);
				bd  = 7'd0;
				bmo = 7'd0;
				nxt.millis       = ld_ms;
				nxt.second_tens  = bs[6:4];
				nxt.second_units = bs[3:0];
				nxt.minute_tens  = bm[6:4];
				nxt.minute_units = bm[3:0];
				nxt.hour_tens    = bh[5:4];
				nxt.hour_units   = bh[3:0];
			end
			btdc_pkg::REQ_SET_DATE: begin
				bs  = 7'd0;
				bm  = 7'd0;
				bh  = 7'd0;
				bd  = btdc_pkg::bin_to_bcd(ld_d);
				bmo = btdc_pkg::bin_to_bcd(ld_mo);
				nxt.day_tens    = bd[5:4];
				nxt.day_units   = bd[3:0];
				nxt.month_tens  = bmo[4];
				nxt.month_units = bmo[3:0];
				nxt.year_now    = req.set_year;
			end
			default: begin
				bs  = 7'd0;
				bm  = 7'd0;
				bh  = 7'd0;
				bd  = 7'd0;
				bmo = 7'd0;
			end
		endcase
	end

endmodule

`default_nettype wire
